@@ src/slte_pkg.sv @@
// Shared widths, codes and controller/datapath handshake types for the sorted list engine.
package slte_pkg;

  localparam int DepthDefault = 64;
  localparam int ValueW       = 32;
  localparam int TypeW        = 2;
  localparam int PosW         = 6;
  localparam int CntW         = 7;
  localparam int StatusW      = 2;
  localparam int IdxW         = 6;

  typedef enum logic [TypeW-1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_REVERSE = 2'd2
  } req_kind_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_DEL_BAD = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ACT_IDLE,
    ACT_WAIT,
    ACT_INS_RD,
    ACT_INS_SHIFT,
    ACT_INS_PUT,
    ACT_DEL_RD,
    ACT_DEL_WR,
    ACT_DEL_END,
    ACT_REV_RDA,
    ACT_REV_RDB,
    ACT_REV_WRA,
    ACT_REV_WRB,
    ACT_REWIND,
    ACT_STR_RD,
    ACT_STR_OUT,
    ACT_OUT_EMPTY,
    ACT_OUT_BAD,
    ACT_OUT_FULL
  } act_t;

  typedef struct packed {
    act_t act;
    logic ready;
  } slte_cmd_t;

  typedef struct packed {
    logic             in_fire;
    logic [TypeW-1:0] req_type;
    logic             full;
    logic             del_bad;
    logic             ins_more;
    logic             ins_gt;
    logic             del_more;
    logic             rev_more;
    logic             empty;
    logic             last;
    logic             out_free;
  } slte_sts_t;

endpackage

@@ src/slte_if.sv @@
// Request and result channel interfaces for the sorted list engine.
interface slte_req_if import slte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TypeW-1:0]     req_type;
  logic signed [ValueW-1:0] value;
  logic [PosW-1:0]      position;
  logic [CntW-1:0]      count;

  modport source (output valid, output req_type, output value, output position,
                  output count, input ready);
  modport sink   (input valid, input req_type, input value, input position,
                  input count, output ready);
endinterface

interface slte_rsp_if import slte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic signed [ValueW-1:0] element;
  logic [IdxW-1:0]          index;
  logic                     empty_res;
  logic                     last;

  modport source (output valid, output status, output element, output index,
                  output empty_res, output last, input ready);
  modport sink   (input valid, input status, input element, input index,
                  input empty_res, input last, output ready);
endinterface

@@ src/slte_ctrl.sv @@
// Controller state machine: sequences insert, delete, reverse and list streaming.
module slte_ctrl import slte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  slte_sts_t sts,
  output slte_cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_INS_RD  = 14'b00000000000010,
    S_INS_CMP = 14'b00000000000100,
    S_DEL_RD  = 14'b00000000001000,
    S_DEL_WR  = 14'b00000000010000,
    S_REV_RDA = 14'b00000000100000,
    S_REV_RDB = 14'b00000001000000,
    S_REV_WRA = 14'b00000010000000,
    S_REV_WRB = 14'b00000100000000,
    S_STR_RD  = 14'b00001000000000,
    S_STR_OUT = 14'b00010000000000,
    S_EMPTY   = 14'b00100000000000,
    S_BAD     = 14'b01000000000000,
    S_FULL    = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.act    = ACT_WAIT;
    cmd.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.act   = ACT_IDLE;
        cmd.ready = 1'b1;
        if (sts.in_fire) begin
          case (sts.req_type)
            REQ_INSERT:  state_next = sts.full ? S_FULL : S_INS_RD;
            REQ_DELETE:  state_next = sts.del_bad ? S_BAD : S_DEL_RD;
            REQ_REVERSE: state_next = S_REV_RDA;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        // at the bottom of the list: place the value in slot zero
        if (sts.ins_more) begin
          cmd.act    = ACT_INS_RD;
          state_next = S_INS_CMP;
        end else begin
          cmd.act    = ACT_INS_PUT;
          state_next = S_STR_RD;
        end
      end
      S_INS_CMP: begin
        if (sts.ins_gt) begin
          cmd.act    = ACT_INS_SHIFT;
          state_next = S_INS_RD;
        end else begin
          cmd.act    = ACT_INS_PUT;
          state_next = S_STR_RD;
        end
      end
      S_DEL_RD: begin
        if (sts.del_more) begin
          cmd.act    = ACT_DEL_RD;
          state_next = S_DEL_WR;
        end else begin
          cmd.act    = ACT_DEL_END;
          state_next = S_STR_RD;
        end
      end
      S_DEL_WR: begin
        cmd.act    = ACT_DEL_WR;
        state_next = S_DEL_RD;
      end
      S_REV_RDA: begin
        if (sts.rev_more) begin
          cmd.act    = ACT_REV_RDA;
          state_next = S_REV_RDB;
        end else begin
          cmd.act    = ACT_REWIND;
          state_next = S_STR_RD;
        end
      end
      S_REV_RDB: begin
        cmd.act    = ACT_REV_RDB;
        state_next = S_REV_WRA;
      end
      S_REV_WRA: begin
        cmd.act    = ACT_REV_WRA;
        state_next = S_REV_WRB;
      end
      S_REV_WRB: begin
        cmd.act    = ACT_REV_WRB;
        state_next = S_REV_RDA;
      end
      S_STR_RD: begin
        if (sts.empty) begin
          state_next = S_EMPTY;
        end else begin
          cmd.act    = ACT_STR_RD;
          state_next = S_STR_OUT;
        end
      end
      S_STR_OUT: begin
        // hold the read data until the output register frees up
        if (sts.out_free) begin
          cmd.act    = ACT_STR_OUT;
          state_next = sts.last ? S_IDLE : S_STR_RD;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.act    = ACT_OUT_EMPTY;
          state_next = S_IDLE;
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.act    = ACT_OUT_BAD;
          state_next = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts.out_free) begin
          cmd.act    = ACT_OUT_FULL;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/slte_dp.sv @@
// Datapath: entry memory, list length, scan pointers and the result register.
module slte_dp import slte_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  slte_cmd_t    cmd,
  output slte_sts_t    sts,
  slte_req_if.sink     req,
  slte_rsp_if.source   rsp
);

  localparam int AW   = $clog2(DEPTH);
  localparam int LW   = $clog2(DEPTH + 1);
  localparam int SumW = CntW + 1;

  logic [ValueW-1:0]        mem [DEPTH];
  logic signed [ValueW-1:0] rdata;
  logic signed [ValueW-1:0] val;
  logic signed [ValueW-1:0] tmp;
  logic [CntW-1:0]          cnt;
  logic [LW-1:0]            len;
  logic [LW-1:0]            ia;
  logic [LW-1:0]            ib;
  logic                     out_valid;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [ValueW-1:0] wr_data;
  logic [SumW-1:0]   ia_cnt;
  logic [SumW-1:0]   req_end;
  logic              fire;
  logic              out_free;

  assign fire     = req.valid && cmd.ready;
  assign out_free = !out_valid || rsp.ready;
  assign ia_cnt   = SumW'(ia) + SumW'(cnt);
  assign req_end  = SumW'(req.position) + SumW'(req.count);

  assign req.ready = cmd.ready;
  assign rsp.valid = out_valid;

  assign sts.in_fire  = fire;
  assign sts.req_type = req.req_type;
  assign sts.full     = (len == LW'(DEPTH));
  assign sts.del_bad  = (SumW'(req.position) >= SumW'(len)) || (req_end > SumW'(len));
  assign sts.ins_more = (ia != '0);
  assign sts.ins_gt   = (val < rdata);
  assign sts.del_more = (ia_cnt < SumW'(len));
  assign sts.rev_more = (ia < ib);
  assign sts.empty    = (len == '0);
  assign sts.last     = ((ia + LW'(1)) == len);
  assign sts.out_free = out_free;

  // memory port decode
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata;
    unique case (cmd.act)
      ACT_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ia - LW'(1));
      end
      ACT_INS_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(ia);
      end
      ACT_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(ia);
        wr_data = val;
      end
      ACT_DEL_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ia_cnt);
      end
      ACT_DEL_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(ia);
      end
      ACT_REV_RDA, ACT_STR_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ia);
      end
      ACT_REV_RDB: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ib);
      end
      ACT_REV_WRA: begin
        wr_en   = 1'b1;
        wr_addr = AW'(ia);
      end
      ACT_REV_WRB: begin
        wr_en   = 1'b1;
        wr_addr = AW'(ib);
        wr_data = tmp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // control state: list length and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.act)
        ACT_INS_PUT: len <= len + LW'(1);
        ACT_DEL_END: len <= len - LW'(cnt);
        default: begin
        end
      endcase
      if (cmd.act == ACT_STR_OUT || cmd.act == ACT_OUT_EMPTY ||
          cmd.act == ACT_OUT_BAD || cmd.act == ACT_OUT_FULL) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pointers and operands
  always_ff @(posedge clk) begin
    if (fire) begin
      val <= req.value;
      cnt <= req.count;
      ib  <= (len == '0) ? '0 : len - LW'(1);
      case (req.req_type)
        REQ_INSERT: ia <= len;
        REQ_DELETE: ia <= LW'(req.position);
        default:    ia <= '0;
      endcase
    end else begin
      case (cmd.act)
        ACT_INS_SHIFT: ia <= ia - LW'(1);
        ACT_DEL_WR:    ia <= ia + LW'(1);
        ACT_REV_RDB:   tmp <= rdata;
        ACT_REV_WRB: begin
          ia <= ia + LW'(1);
          ib <= ib - LW'(1);
        end
        ACT_STR_OUT:   ia <= ia + LW'(1);
        ACT_INS_PUT, ACT_DEL_END, ACT_REWIND: ia <= '0;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_STR_OUT: begin
        rsp.status    <= ST_OK;
        rsp.element   <= rdata;
        rsp.index     <= IdxW'(ia);
        rsp.empty_res <= 1'b0;
        rsp.last      <= sts.last;
      end
      ACT_OUT_EMPTY: begin
        rsp.status    <= ST_OK;
        rsp.element   <= '0;
        rsp.index     <= '0;
        rsp.empty_res <= 1'b1;
        rsp.last      <= 1'b1;
      end
      ACT_OUT_BAD: begin
        rsp.status    <= ST_DEL_BAD;
        rsp.element   <= '0;
        rsp.index     <= '0;
        rsp.empty_res <= 1'b0;
        rsp.last      <= 1'b1;
      end
      ACT_OUT_FULL: begin
        rsp.status    <= ST_FULL;
        rsp.element   <= '0;
        rsp.index     <= '0;
        rsp.empty_res <= 1'b0;
        rsp.last      <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(DEPTH))
    else $error("list length beyond depth");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == ACT_STR_OUT || cmd.act == ACT_OUT_EMPTY ||
     cmd.act == ACT_OUT_BAD || cmd.act == ACT_OUT_FULL) |-> out_free)
    else $error("result register overwritten while occupied");

  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == ACT_INS_PUT) |=> (len == $past(len) + LW'(1)))
    else $error("insert did not grow the list");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == ACT_REV_WRB) |-> (ia < ib))
    else $error("reverse swap with crossed pointers");

endmodule

@@ src/sorted_list_table_engine_unit.sv @@
// Top level of the sorted list engine: controller plus datapath.
// Insert: each greater entry is shifted up a slot, then the value fills the gap;
// delete: entries past the range move down by the count; reverse: end pairs are swapped.
// On success the list is then streamed one result at a time (read, then load the output
// register once it is free). One item is worked at a time; the next is taken as soon as
// the last result is loaded. Reset empties the list at once, no clearing pass.
module sorted_list_table_engine_unit import slte_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  slte_req_if.sink   req,
  slte_rsp_if.source rsp
);

  slte_cmd_t cmd;
  slte_sts_t sts;

  slte_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  slte_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule

@@ dv/sorted_list_table_engine_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sorted list engine: insert, range delete, reverse, list stream.
module sorted_list_table_engine_unit_test;
  import slte_pkg::*;

  localparam int Depth      = DepthDefault;
  localparam int RandomReqs = 450;
  localparam int TailCycles = 300;
  localparam int CycleLimit = 2_000_000;
  localparam int MaxReports = 10;

  localparam logic [TypeW-1:0] ReqUnused = 2'd3;

  typedef logic signed [ValueW-1:0] word_t;

  typedef struct {
    logic [TypeW-1:0] req_type;
    word_t            value;
    logic [PosW-1:0]  position;
    logic [CntW-1:0]  count;
  } list_req_t;

  typedef struct {
    status_t         status;
    word_t           element;
    logic [IdxW-1:0] index;
    logic            empty_res;
    logic            last;
  } list_rsp_t;

  logic clk;
  logic rst;

  slte_req_if req_ch ();
  slte_rsp_if rsp_ch ();

  sorted_list_table_engine_unit #(.DEPTH(Depth)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];
  word_t     shadow_list[$];

  int gen_len;
  int reqs_taken;
  int total_reqs;
  int mismatches;
  int cycle_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic list_rsp_t make_rsp(status_t st, word_t elem, int idx, logic emp,
                                         logic lst);
    list_rsp_t r;
    r.status    = st;
    r.element   = elem;
    r.index     = idx[IdxW-1:0];
    r.empty_res = emp;
    r.last      = lst;
    return r;
  endfunction

  // Expect the whole list in index order, or one empty-marked item.
  function automatic void expect_list_stream();
    int n;
    n = shadow_list.size();
    if (n == 0) begin
      expected_rsps.push_back(make_rsp(ST_OK, '0, 0, 1'b1, 1'b1));
    end else begin
      for (int m = 0; m < n; m++) begin
        expected_rsps.push_back(make_rsp(ST_OK, shadow_list[m], m, 1'b0, m == n - 1));
      end
    end
  endfunction

  function automatic void predict_list(list_req_t r);
    int    n;
    int    i;
    int    a;
    int    b;
    word_t t;
    n = shadow_list.size();
    case (r.req_type)
      REQ_INSERT: begin
        if (n >= Depth) begin
          expected_rsps.push_back(make_rsp(ST_FULL, '0, 0, 1'b0, 1'b1));
        end else begin
          // scan down from the top; stop at the first entry not greater
          i = n;
          while (i > 0 && r.value < shadow_list[i-1]) i--;
          shadow_list.insert(i, r.value);
          expect_list_stream();
        end
      end
      REQ_DELETE: begin
        if (int'(r.position) >= n || int'(r.position) + int'(r.count) > n) begin
          expected_rsps.push_back(make_rsp(ST_DEL_BAD, '0, 0, 1'b0, 1'b1));
        end else begin
          repeat (int'(r.count)) shadow_list.delete(int'(r.position));
          expect_list_stream();
        end
      end
      REQ_REVERSE: begin
        a = 0;
        b = n - 1;
        while (a < b) begin
          t              = shadow_list[a];
          shadow_list[a] = shadow_list[b];
          shadow_list[b] = t;
          a++;
          b--;
        end
        expect_list_stream();
      end
      default: ;
    endcase
  endfunction

  // Track the list length while queuing, so random items can aim at real entries.
  task automatic add_req(input logic [TypeW-1:0] kind, input word_t v, input int pos,
                         input int cnt);
    list_req_t r;
    r.req_type = kind;
    r.value    = v;
    r.position = pos[PosW-1:0];
    r.count    = cnt[CntW-1:0];
    pending_reqs.push_back(r);
    if (kind == REQ_INSERT && gen_len < Depth) begin
      gen_len++;
    end else if (kind == REQ_DELETE && pos < gen_len && pos + cnt <= gen_len) begin
      gen_len -= cnt;
    end
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 4))
      0, 1: return word_t'($urandom);
      2, 3: return word_t'($urandom_range(0, 16) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0: return word_t'(32'h7fff_ffff);
          1: return word_t'(32'h8000_0000);
          2: return word_t'(0);
          default: return word_t'(-1);
        endcase
      end
    endcase
  endfunction

  task automatic queue_directed();
    add_req(REQ_DELETE, 0, 0, 0);                  // delete on empty list
    add_req(REQ_REVERSE, 0, 0, 0);                 // empty list stream
    add_req(ReqUnused, -1, 63, 127);               // unused code, ignored
    add_req(REQ_INSERT, 0, 0, 0);
    add_req(REQ_INSERT, 32'h7fff_ffff, 0, 0);
    add_req(REQ_INSERT, 32'h8000_0000, 0, 0);
    add_req(REQ_INSERT, -1, 0, 0);
    add_req(REQ_INSERT, 1, 0, 0);
    add_req(REQ_INSERT, 1, 0, 0);                  // duplicate lands above its twin
    add_req(REQ_REVERSE, 0, 0, 0);
    add_req(REQ_INSERT, 5, 0, 0);                  // lands on top of a descending list
    add_req(REQ_DELETE, 0, 0, 0);                  // zero count, list unchanged
    add_req(REQ_DELETE, 0, 7, 0);                  // position at the length
    add_req(REQ_DELETE, 0, 2, 6);                  // range runs past the end
    add_req(REQ_DELETE, 0, 63, 127);
    add_req(REQ_DELETE, 0, 1, 2);
    add_req(REQ_REVERSE, 0, 0, 0);
    add_req(REQ_DELETE, 0, 0, 5);                  // delete everything
    add_req(REQ_INSERT, -5, 0, 0);
    add_req(REQ_REVERSE, 0, 0, 0);                 // single entry
  endtask

  // Alternate between growing to full (and past it) and draining back down.
  task automatic queue_random();
    int made;
    int roll;
    int pos;
    int cnt;
    bit grow;
    int full_hits;
    made      = 0;
    grow      = 1'b1;
    full_hits = 0;
    while (made < RandomReqs) begin
      if (grow && full_hits >= 2) begin
        grow      = 1'b0;
        full_hits = 0;
      end else if (!grow && gen_len < 4) begin
        grow = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < (grow ? 80 : 22)) begin
        if (gen_len == Depth) full_hits++;
        add_req(REQ_INSERT, pick_value(), $urandom_range(0, 63), $urandom_range(0, 127));
        made++;
      end else if (roll < (grow ? 88 : 80)) begin
        if (gen_len == 0) begin
          pos = 0;
          cnt = 0;
        end else if (gen_len == Depth && $urandom_range(0, 5) == 0) begin
          pos = 0;
          cnt = Depth;
        end else if ($urandom_range(0, 3) == 0) begin
          pos = gen_len - 1;
          cnt = $urandom_range(0, 1);
        end else begin
          pos = $urandom_range(0, gen_len - 1);
          cnt = $urandom_range(0, (gen_len - pos < 8) ? gen_len - pos : 8);
        end
        add_req(REQ_DELETE, word_t'($urandom), pos, cnt);
        made++;
      end else if (roll < 95) begin
        add_req(REQ_REVERSE, word_t'($urandom), $urandom_range(0, 63), $urandom_range(0, 127));
        made++;
      end else if (roll < 98) begin
        add_req(REQ_DELETE, word_t'($urandom), $urandom_range(0, 63), $urandom_range(0, 127));
        made++;
      end else begin
        add_req(ReqUnused, word_t'($urandom), $urandom_range(0, 63), $urandom_range(0, 127));
      end
    end
  endtask

  // Idle percentage for the current phase of the run.
  function automatic int gap_pct(bit for_sender);
    int ph;
    ph = (total_reqs == 0) ? 0 : reqs_taken * 4 / total_reqs;
    case (ph)
      0: return 0;
      1: return for_sender ? 46 : 0;
      2: return for_sender ? 0 : 46;
      default: return 35;
    endcase
  endfunction

  // Request driver: hold the item until taken, then maybe idle before the next one.
  always @(posedge clk) begin
    bit load_next;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      load_next = !req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        predict_list(pending_reqs.pop_front());
        reqs_taken <= reqs_taken + 1;
        load_next = 1'b1;
      end
      if (load_next) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct(1'b1)) begin
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= pending_reqs[0].req_type;
          req_ch.value    <= pending_reqs[0].value;
          req_ch.position <= pending_reqs[0].position;
          req_ch.count    <= pending_reqs[0].count;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each taken item against the oldest expectation.
  always @(posedge clk) begin
    list_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          if (mismatches < MaxReports) begin
            $display("%0t: unexpected item: status %0d element %0d index %0d empty %0b last %0b",
                     $realtime, rsp_ch.status, rsp_ch.element, rsp_ch.index,
                     rsp_ch.empty_res, rsp_ch.last);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.element !== want.element ||
              rsp_ch.index !== want.index || rsp_ch.empty_res !== want.empty_res ||
              rsp_ch.last !== want.last) begin
            if (mismatches < MaxReports) begin
              $display("%0t: mismatch: expected status %0d element %0d index %0d empty %0b last %0b",
                       $realtime, want.status, want.element, want.index, want.empty_res,
                       want.last);
              $display("%0t:           got      status %0d element %0d index %0d empty %0b last %0b",
                       $realtime, rsp_ch.status, rsp_ch.element, rsp_ch.index,
                       rsp_ch.empty_res, rsp_ch.last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= gap_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[sorted_list_table_engine_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = '0;
    req_ch.value    = '0;
    req_ch.position = '0;
    req_ch.count    = '0;
    rsp_ch.ready    = 1'b0;
    gen_len         = 0;
    reqs_taken      = 0;
    mismatches      = 0;
    cycle_count     = 0;
    queue_directed();
    queue_random();
    total_reqs = pending_reqs.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    // let a trailing ignored item and any stray output settle
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("[sorted_list_table_engine_unit] OK");
    end else begin
      $display("[sorted_list_table_engine_unit] ERROR");
    end
    $finish;
  end

endmodule
